// ===== hw/rtl/all_pairs_shortest_path_via_node_core_macros.svh =====
// Assertion helpers for the route core.
`ifndef ALL_PAIRS_SHORTEST_PATH_VIA_NODE_CORE_MACROS_SVH
`define ALL_PAIRS_SHORTEST_PATH_VIA_NODE_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define APSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define APSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== hw/rtl/apsp_pkg.sv =====
`timescale 1ns / 1ps
package apsp_pkg;
   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_ADD     = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;
   localparam logic [1:0] CMD_QUERY   = 2'd3;

   localparam int REG_DISCOUNT_NODE = 0;
   localparam int REG_NODE_COUNT    = 1;

   // Memory operations the controller asks of the datapath.
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_CLR    = 3'd1;  // write diagonal/infinity at addr_a
   localparam logic [2:0] OP_RD     = 3'd2;  // read both matrices at a, b and c
   localparam logic [2:0] OP_ADD_WR = 3'd3;  // min-update edge at addr_a
   localparam logic [2:0] OP_RLX_WR = 3'd4;  // relax entry at addr_a
   localparam logic [2:0] OP_QRY    = 3'd5;  // capture query answer

   typedef struct packed {
      logic [2:0] op;
      logic       diag;
      logic       use_disc;
      logic       in_range;
   } cmd_type;
endpackage

// ===== hw/rtl/all_pairs_shortest_path_via_node_core.sv =====
`timescale 1ns / 1ps
// Add edge: read, then min-write; query: read, sum, capture, then hold the result until taken; clear: every entry.
// Compute: one read-sum-write pass of the shared relax unit per matrix entry and per intermediate
// node, for n = min(node_count, MAX_NODES).
// Reset is synchronous; after it the core sweeps both matrices, stalling requests,
// while configuration writes are taken as ever.
module all_pairs_shortest_path_via_node_core #(
   parameter int MAX_NODES = 64,
   parameter int DIST_BITS = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_command,
   input  logic [5:0]           req_src_node,
   input  logic [5:0]           req_dst_node,
   input  logic [29:0]          req_edge_weight,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_reachable,
   output logic [39:0]          rsp_route_cost,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   localparam int NB = $clog2(MAX_NODES);
   localparam logic [DIST_BITS-1:0] INF = {DIST_BITS{1'b1}};

   logic [5:0]           disc_ff;
   logic [6:0]           count_ff;
   apsp_pkg::cmd_type    cmd;
   logic [2*NB-1:0]      addr_a, addr_b, addr_c;
   logic [29:0]          weight;
   logic [DIST_BITS-1:0] answer;
   logic                 wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         disc_ff  <= '0;
         count_ff <= 7'd64;
      end else if (wr) begin
         if (paddr[2] == 1'(apsp_pkg::REG_DISCOUNT_NODE) && paddr[1:0] == 2'd0)
            disc_ff <= pwdata[5:0];
         else if (paddr[2] == 1'(apsp_pkg::REG_NODE_COUNT) && paddr[1:0] == 2'd0)
            count_ff <= pwdata[6:0];
      end
   end
   always_comb begin
      prdata = '0;
      if (paddr == 3'(4 * apsp_pkg::REG_DISCOUNT_NODE)) prdata = 32'(disc_ff);
      else if (paddr == 3'(4 * apsp_pkg::REG_NODE_COUNT)) prdata = 32'(count_ff);
   end

   apsp_ctrl #(.NB(NB), .MAX_NODES(MAX_NODES)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_command, .req_src_node,
      .req_dst_node, .req_edge_weight, .rsp_valid, .rsp_stall,
      .discount_node(disc_ff), .node_count(count_ff), .cmd, .addr_a, .addr_b,
      .addr_c, .weight);

   apsp_dpath #(.AW(2*NB), .DIST_BITS(DIST_BITS)) u_dpath (
      .clock, .reset, .cmd, .addr_a, .addr_b, .addr_c, .weight, .answer);

   assign rsp_reachable  = answer != INF;
   assign rsp_route_cost = (answer != INF) ? 40'(answer) : 40'd0;
endmodule

// ===== hw/rtl/apsp_dpath.sv =====
`timescale 1ns / 1ps
`include "all_pairs_shortest_path_via_node_core_macros.svh"
module apsp_dpath #(
   parameter int AW = 12,
   parameter int DIST_BITS = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  apsp_pkg::cmd_type    cmd,
   input  logic [AW-1:0]        addr_a,
   input  logic [AW-1:0]        addr_b,
   input  logic [AW-1:0]        addr_c,
   input  logic [29:0]          weight,
   output logic [DIST_BITS-1:0] answer
);
   localparam logic [DIST_BITS-1:0] INF = {DIST_BITS{1'b1}};

   // Each matrix has three read ports realized as three copies of one memory.
   logic [DIST_BITS-1:0] p_a [2**AW];
   logic [DIST_BITS-1:0] p_b [2**AW];
   logic [DIST_BITS-1:0] p_c [2**AW];
   logic [DIST_BITS-1:0] d_a [2**AW];
   logic [DIST_BITS-1:0] d_b [2**AW];
   logic [DIST_BITS-1:0] d_c [2**AW];
   logic [DIST_BITS-1:0] pa_ff, pb_ff, pc_ff, da_ff, db_ff, dc_ff;
   logic [DIST_BITS-1:0] psum_ff, dsum_ff, answer_ff;
   logic [DIST_BITS-1:0] p_wr, d_wr, w_ext, wd_ext, psum_in, dsum_in, best;
   logic                 wr_en;

   function automatic logic [DIST_BITS-1:0] sat_add(input logic [DIST_BITS-1:0] a,
                                                   input logic [DIST_BITS-1:0] b);
      logic [DIST_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (a == INF || b == INF || s[DIST_BITS] || s[DIST_BITS-1:0] == INF) begin
         return INF;
      end
      return s[DIST_BITS-1:0];
   endfunction

   assign w_ext  = DIST_BITS'(weight);
   assign wd_ext = (weight == 30'd0) ? '0 : DIST_BITS'(weight - 30'd1);
   // The sum is registered on read so the write cycle has only a compare.
   assign psum_in = sat_add(pb_ff, pc_ff);
   assign dsum_in = sat_add(db_ff, dc_ff);

   always_comb begin
      wr_en = 1'b0;
      p_wr  = pa_ff;
      d_wr  = da_ff;
      unique case (cmd.op)
         apsp_pkg::OP_CLR: begin
            wr_en = 1'b1;
            p_wr  = cmd.diag ? '0 : INF;
            d_wr  = cmd.diag ? '0 : INF;
         end
         apsp_pkg::OP_ADD_WR: begin
            wr_en = 1'b1;
            p_wr  = (w_ext < pa_ff) ? w_ext : pa_ff;
            d_wr  = (wd_ext < da_ff) ? wd_ext : da_ff;
         end
         apsp_pkg::OP_RLX_WR: begin
            wr_en = 1'b1;
            p_wr  = (psum_ff < pa_ff) ? psum_ff : pa_ff;
            d_wr  = (dsum_ff < da_ff) ? dsum_ff : da_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         p_a[addr_a] <= p_wr;
         p_b[addr_a] <= p_wr;
         p_c[addr_a] <= p_wr;
         d_a[addr_a] <= d_wr;
         d_b[addr_a] <= d_wr;
         d_c[addr_a] <= d_wr;
      end
      pa_ff <= p_a[addr_a];
      pb_ff <= p_b[addr_b];
      pc_ff <= p_c[addr_c];
      da_ff <= d_a[addr_a];
      db_ff <= d_b[addr_b];
      dc_ff <= d_c[addr_c];
      psum_ff <= psum_in;
      dsum_ff <= dsum_in;
   end

   always_comb begin
      best = cmd.in_range ? pa_ff : INF;
      if (cmd.in_range && cmd.use_disc && dsum_ff < best) begin
         best = dsum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         answer_ff <= INF;
      end else if (cmd.op == apsp_pkg::OP_QRY) begin
         answer_ff <= best;
      end
   end
   assign answer = answer_ff;

   `APSP_ASSERT_NEXT(a_qry_cap, clock, reset, cmd.op == apsp_pkg::OP_QRY && !cmd.in_range, answer == INF, "out-of-range query not infinite")
   `APSP_ASSERT_IMPL(a_clr_diag, clock, reset, cmd.op == apsp_pkg::OP_CLR && cmd.diag, p_wr == '0 && d_wr == '0, "diagonal clear not zero")
   `APSP_ASSERT_IMPL(a_rlx_mono, clock, reset, cmd.op == apsp_pkg::OP_RLX_WR, p_wr <= pa_ff && d_wr <= da_ff, "relax grew a distance")
endmodule

// ===== hw/rtl/apsp_ctrl.sv =====
`timescale 1ns / 1ps
`include "all_pairs_shortest_path_via_node_core_macros.svh"
module apsp_ctrl #(
   parameter int NB = 6,
   parameter int MAX_NODES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [5:0]         req_src_node,
   input  logic [5:0]         req_dst_node,
   input  logic [29:0]        req_edge_weight,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [5:0]         discount_node,
   input  logic [6:0]         node_count,
   output apsp_pkg::cmd_type  cmd,
   output logic [2*NB-1:0]    addr_a,
   output logic [2*NB-1:0]    addr_b,
   output logic [2*NB-1:0]    addr_c,
   output logic [29:0]        weight
);
   localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_CLR = 4'd2, S_ADD_RD = 4'd3,
      S_ADD_WR = 4'd4, S_Q_RD = 4'd5, S_Q_SUM = 4'd6, S_Q_CAP = 4'd7,
      S_RSP = 4'd8, S_R_RD = 4'd9, S_R_SUM = 4'd10, S_R_WR = 4'd11;
   localparam int CW = (NB > 7) ? NB + 1 : 8;

   logic [3:0]      state_ff, state_in;
   logic [2*NB-1:0] clr_ff, clr_in;
   logic [NB-1:0]   k_ff, k_in, i_ff, i_in, j_ff, j_in;
   logic [NB-1:0]   src_ff, src_in, dst_ff, dst_in;
   logic [29:0]     w_ff, w_in;
   logic            rng_ff, rng_in;
   logic            disc_ok;
   logic [NB-1:0]   dn, last;
   logic [CW-1:0]   nc_ext;
   logic [NB:0]     n_eff;

   assign disc_ok = CW'(discount_node) < CW'(MAX_NODES);
   assign dn      = NB'(discount_node);
   assign nc_ext  = CW'(node_count);
   assign n_eff   = (nc_ext > CW'(MAX_NODES)) ? (NB+1)'(MAX_NODES) : (NB+1)'(nc_ext);
   assign last    = NB'(n_eff - (NB+1)'(1));

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RSP;
   assign weight    = w_ff;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff; k_in = k_ff; i_in = i_ff; j_in = j_ff;
      src_in = src_ff; dst_in = dst_ff; w_in = w_ff; rng_in = rng_ff;
      cmd = '{op: apsp_pkg::OP_NONE, diag: 1'b0, use_disc: disc_ok, in_range: rng_ff};
      addr_a = {src_ff, dst_ff};
      addr_b = {src_ff, dn};
      addr_c = {dn, dst_ff};
      unique case (state_ff)
         S_INIT, S_CLR: begin
            cmd.op = apsp_pkg::OP_CLR;
            cmd.diag = clr_ff[2*NB-1:NB] == clr_ff[NB-1:0];
            addr_a = clr_ff;
            clr_in = clr_ff + (2*NB)'(1);
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               src_in = NB'(req_src_node);
               dst_in = NB'(req_dst_node);
               w_in   = req_edge_weight;
               rng_in = CW'(req_src_node) < CW'(MAX_NODES) &&
                        CW'(req_dst_node) < CW'(MAX_NODES);
               k_in = '0; i_in = '0; j_in = '0; clr_in = '0;
               unique case (req_command)
                  apsp_pkg::CMD_CLEAR:   state_in = S_CLR;
                  apsp_pkg::CMD_ADD:     state_in = S_ADD_RD;
                  apsp_pkg::CMD_COMPUTE: state_in = (node_count == 7'd0) ? S_IDLE : S_R_RD;
                  default:               state_in = S_Q_RD;
               endcase
            end
         end
         S_ADD_RD: begin
            cmd.op = apsp_pkg::OP_RD;
            state_in = rng_ff ? S_ADD_WR : S_IDLE;
         end
         S_ADD_WR: begin
            cmd.op = apsp_pkg::OP_ADD_WR;
            state_in = S_IDLE;
         end
         S_Q_RD: begin
            cmd.op = apsp_pkg::OP_RD;
            state_in = S_Q_SUM;
         end
         S_Q_SUM: state_in = S_Q_CAP;
         S_Q_CAP: begin
            cmd.op = apsp_pkg::OP_QRY;
            state_in = S_RSP;
         end
         S_RSP: if (!rsp_stall) state_in = S_IDLE;
         S_R_RD: begin
            cmd.op = apsp_pkg::OP_RD;
            addr_a = {i_ff, j_ff}; addr_b = {i_ff, k_ff}; addr_c = {k_ff, j_ff};
            state_in = S_R_SUM;
         end
         S_R_SUM: begin
            addr_a = {i_ff, j_ff};
            state_in = S_R_WR;
         end
         S_R_WR: begin
            cmd.op = apsp_pkg::OP_RLX_WR;
            addr_a = {i_ff, j_ff};
            state_in = S_R_RD;
            j_in = j_ff + NB'(1);
            if (j_ff == last) begin
               j_in = '0;
               i_in = i_ff + NB'(1);
               if (i_ff == last) begin
                  i_in = '0;
                  k_in = k_ff + NB'(1);
                  if (k_ff == last) state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         clr_ff <= '0; k_ff <= '0; i_ff <= '0; j_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in; k_ff <= k_in; i_ff <= i_in; j_ff <= j_in;
      end
   end
   always_ff @(posedge clock) begin
      src_ff <= src_in; dst_ff <= dst_in; w_ff <= w_in; rng_ff <= rng_in;
   end

   `APSP_ASSERT_NEXT(a_rsp_after_cap, clock, reset, state_ff == S_Q_CAP, rsp_valid, "query did not answer")
   `APSP_ASSERT_IMPL(a_busy_stall, clock, reset, state_ff != S_IDLE, req_stall, "accepting while busy")
   `APSP_ASSERT_IMPL(a_rlx_bounds, clock, reset, state_ff == S_R_WR, k_ff <= last && i_ff <= last && j_ff <= last, "relax index out of range")
endmodule
